### src/fsfu_pkg.sv
// types, constants and fixed-point helpers shared by the stencil force block
`timescale 1ns / 1ps
package fsfu_pkg;

  localparam int unsigned NUM_DIV_CELLS = 32;

  localparam logic signed [31:0] MAX32 = 32'sh7fff_ffff;
  localparam logic signed [31:0] MIN32 = 32'sh8000_0000;
  localparam logic signed [32:0] ONE_Q = 33'sh0_0100_0000;

  localparam logic signed [31:0] MU_RST        = 32'shec00_0000;
  localparam logic signed [31:0] KAPPA_RST     = 32'sh1400_0000;
  localparam logic signed [31:0] MASS_SQ_RST   = 32'sh0100_0000;
  localparam logic signed [31:0] INV_DX_SQ_RST = 32'sh0a00_0000;

  typedef enum logic [1:0] {
    REG_MU        = 2'd0,
    REG_KAPPA     = 2'd1,
    REG_MASS_SQ   = 2'd2,
    REG_INV_DX_SQ = 2'd3
  } cfg_reg_e;

  typedef enum logic [1:0] {
    KIND_COMP0 = 2'd0,
    KIND_COMP1 = 2'd1,
    KIND_COMP2 = 2'd2
  } kind_e;

  typedef struct packed {
    logic [1:0]         kind;
    logic signed [31:0] comp0_value;
    logic signed [31:0] comp1_value;
    logic signed [31:0] comp2_value;
    logic signed [31:0] nbr_x_plus;
    logic signed [31:0] nbr_x_minus;
    logic signed [31:0] nbr_y_plus;
    logic signed [31:0] nbr_y_minus;
    logic signed [31:0] nbr_z_plus;
    logic signed [31:0] nbr_z_minus;
    logic               on_edge;
  } req_t;

  typedef struct packed {
    logic signed [31:0] accel;
  } rsp_t;

  // state carried along the divider chain
  typedef struct packed {
    logic [30:0]        r;
    logic [30:0]        d;
    logic [31:0]        nb;
    logic [31:0]        q;
    logic               neg;
    logic               zero;
    logic               ovf;
    logic               on_edge;
    logic signed [32:0] base;
  } div_t;

  // floor(p / 2^24) saturated to 32 bits
  function automatic logic signed [31:0] mulq_sat(input logic signed [67:0] p);
    logic signed [43:0] s;
    s = 44'(p >>> 24);
    if (s > 44'(MAX32)) begin
      return MAX32;
    end else if (s < 44'(MIN32)) begin
      return MIN32;
    end
    return s[31:0];
  endfunction

endpackage

### src/fsfu_req_if.sv
// request channel carrying one stencil cell
`timescale 1ns / 1ps
interface fsfu_req_if;
  logic           valid;
  logic           ready;
  fsfu_pkg::req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### src/fsfu_rsp_if.sv
// response channel carrying one acceleration
`timescale 1ns / 1ps
interface fsfu_rsp_if;
  logic           valid;
  logic           ready;
  fsfu_pkg::rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### src/fsfu_div_cell.sv
// one restoring-division cell: produces one quotient bit per request
`timescale 1ns / 1ps
module fsfu_div_cell (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  fsfu_pkg::div_t in_data_i,
  output logic           in_adv_o,
  output logic           out_valid_o,
  output fsfu_pkg::div_t out_data_o,
  input  logic           out_adv_i
);
  import fsfu_pkg::*;

  logic  valid_q;
  div_t  data_q, data_d;
  logic [31:0] trial;
  logic        ge;

  assign in_adv_o = !valid_q || out_adv_i;

  always_comb begin
    data_d = in_data_i;
    trial  = {in_data_i.r, in_data_i.nb[31]};
    ge     = trial >= {1'b0, in_data_i.d};
    data_d.r  = ge ? 31'(trial - {1'b0, in_data_i.d}) : trial[30:0];
    data_d.q  = {in_data_i.q[30:0], ge};
    data_d.nb = {in_data_i.nb[30:0], 1'b0};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_adv_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_adv_o) begin
      data_q <= data_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;
endmodule

### src/field_stencil_force_update.sv
// top level of the stencil force block: arithmetic front end, divider chain, output register
`timescale 1ns / 1ps
// Computes, per request, the acceleration of one field component at one grid cell:
// inv_dx_sq * (six neighbours - 6*phi) - mass_sq*phi - mu*P*dP/(1+kappa*P^2)^2, in signed
// Q8.24 with truncating products and a saturated result; cells flagged on_edge give zero.
// A new request is taken every cycle unless a stall backs up to the input, and results
// stream out in order. The pipe has seven arithmetic stages (at most one multiplier
// level each), a chain of 32 division cells that each resolve one quotient bit, and the
// output register. Every stage keeps its own valid bit, so bubbles close up while the
// output is stalled and the request side stays ready until the whole pipe is full.
// Configuration writes take effect at once and belong to idle periods.
module field_stencil_force_update (
  input  logic        clk_i,
  input  logic        rst_ni,
  fsfu_req_if.sink    req_i,
  fsfu_rsp_if.source  rsp_o,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i
);
  import fsfu_pkg::*;

  localparam int unsigned NFRONT = 7;

  // configuration registers
  logic signed [31:0] mu_q, kappa_q, mass_sq_q, inv_dx_sq_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mu_q        <= MU_RST;
      kappa_q     <= KAPPA_RST;
      mass_sq_q   <= MASS_SQ_RST;
      inv_dx_sq_q <= INV_DX_SQ_RST;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_MU:        mu_q        <= cfg_data_i;
        REG_KAPPA:     kappa_q     <= cfg_data_i;
        REG_MASS_SQ:   mass_sq_q   <= cfg_data_i;
        REG_INV_DX_SQ: inv_dx_sq_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // stage valid bits and the advance chain, last stage first
  logic [NFRONT-1:0] v_q;
  logic [NFRONT:0]   adv;
  logic              chain_adv;
  logic              out_valid_q;
  logic              out_adv;

  assign out_adv = !out_valid_q || rsp_o.ready;

  always_comb begin
    adv[NFRONT] = chain_adv;
    for (int k = NFRONT - 1; k >= 0; k--) begin
      adv[k] = !v_q[k] || adv[k+1];
    end
  end

  assign req_i.ready = adv[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (adv[0]) v_q[0] <= req_i.valid;
      for (int k = 1; k < NFRONT; k++) begin
        if (adv[k]) v_q[k] <= v_q[k-1];
      end
    end
  end

  // stage a: pick the component, stencil sum, the three first products
  logic signed [31:0] self_c, dpa_c, dpb_c;
  logic signed [63:0] dp_p, p01_p, mt_p;
  logic signed [35:0] sum_c, self_x;

  always_comb begin
    case (req_i.data.kind)
      KIND_COMP0: begin
        self_c = req_i.data.comp0_value;
        dpa_c  = req_i.data.comp1_value;
        dpb_c  = req_i.data.comp2_value;
      end
      KIND_COMP1: begin
        self_c = req_i.data.comp1_value;
        dpa_c  = req_i.data.comp0_value;
        dpb_c  = req_i.data.comp2_value;
      end
      default: begin
        // selector three behaves as component two
        self_c = req_i.data.comp2_value;
        dpa_c  = req_i.data.comp0_value;
        dpb_c  = req_i.data.comp1_value;
      end
    endcase
    dp_p   = 64'(dpa_c) * 64'(dpb_c);
    p01_p  = 64'(req_i.data.comp0_value) * 64'(req_i.data.comp1_value);
    mt_p   = 64'(mass_sq_q) * 64'(self_c);
    self_x = 36'(self_c);
    sum_c  = 36'(req_i.data.nbr_x_plus) + 36'(req_i.data.nbr_x_minus)
           + 36'(req_i.data.nbr_y_plus) + 36'(req_i.data.nbr_y_minus)
           + 36'(req_i.data.nbr_z_plus) + 36'(req_i.data.nbr_z_minus)
           - ((self_x <<< 2) + (self_x <<< 1));
  end

  logic               a_edge_q;
  logic signed [35:0] a_sum_q;
  logic signed [31:0] a_dp_q, a_p01_q, a_p2_q, a_mt_q;

  always_ff @(posedge clk_i) begin
    if (adv[0]) begin
      a_edge_q <= req_i.data.on_edge;
      a_sum_q  <= sum_c;
      a_dp_q   <= mulq_sat(68'(dp_p));
      a_p01_q  <= mulq_sat(68'(p01_p));
      a_p2_q   <= req_i.data.comp2_value;
      a_mt_q   <= mulq_sat(68'(mt_p));
    end
  end

  // stage b: laplacian term and the full product P
  logic signed [67:0] lap_p;
  logic signed [63:0] prod_p;
  assign lap_p  = 68'(a_sum_q) * 68'(inv_dx_sq_q);
  assign prod_p = 64'(a_p01_q) * 64'(a_p2_q);

  logic               b_edge_q;
  logic signed [31:0] b_lap_q, b_prod_q, b_dp_q, b_mt_q;

  always_ff @(posedge clk_i) begin
    if (adv[1]) begin
      b_edge_q <= a_edge_q;
      b_lap_q  <= mulq_sat(lap_p);
      b_prod_q <= mulq_sat(68'(prod_p));
      b_dp_q   <= a_dp_q;
      b_mt_q   <= a_mt_q;
    end
  end

  // stage c: P^2, mu*P and the linear part of the result
  logic signed [63:0] psq_p, mup_p;
  assign psq_p = 64'(b_prod_q) * 64'(b_prod_q);
  assign mup_p = 64'(mu_q) * 64'(b_prod_q);

  logic               c_edge_q;
  logic signed [32:0] c_base_q;
  logic signed [31:0] c_psq_q, c_mup_q, c_dp_q;

  always_ff @(posedge clk_i) begin
    if (adv[2]) begin
      c_edge_q <= b_edge_q;
      c_base_q <= 33'(b_lap_q) - 33'(b_mt_q);
      c_psq_q  <= mulq_sat(68'(psq_p));
      c_mup_q  <= mulq_sat(68'(mup_p));
      c_dp_q   <= b_dp_q;
    end
  end

  // stage d: kappa*P^2 and the numerator
  logic signed [63:0] kp_p, num_p;
  assign kp_p  = 64'(kappa_q) * 64'(c_psq_q);
  assign num_p = 64'(c_mup_q) * 64'(c_dp_q);

  logic               d_edge_q;
  logic signed [32:0] d_base_q;
  logic signed [31:0] d_kp_q, d_num_q;

  always_ff @(posedge clk_i) begin
    if (adv[3]) begin
      d_edge_q <= c_edge_q;
      d_base_q <= c_base_q;
      d_kp_q   <= mulq_sat(68'(kp_p));
      d_num_q  <= mulq_sat(68'(num_p));
    end
  end

  // stage e: denominator root D = 1 + kappa*P^2, kept exact
  logic               e_edge_q;
  logic signed [32:0] e_base_q, e_den_q;
  logic signed [31:0] e_num_q;

  always_ff @(posedge clk_i) begin
    if (adv[4]) begin
      e_edge_q <= d_edge_q;
      e_base_q <= d_base_q;
      e_den_q  <= ONE_Q + 33'(d_kp_q);
      e_num_q  <= d_num_q;
    end
  end

  // stage f: D^2, never negative
  logic signed [65:0] den2_p;
  logic signed [31:0] den2_c;
  assign den2_p = 66'(e_den_q) * 66'(e_den_q);
  assign den2_c = mulq_sat(68'(den2_p));

  logic               f_edge_q;
  logic signed [32:0] f_base_q;
  logic [30:0]        f_den2_q;
  logic signed [31:0] f_num_q;

  always_ff @(posedge clk_i) begin
    if (adv[5]) begin
      f_edge_q <= e_edge_q;
      f_base_q <= e_base_q;
      f_den2_q <= den2_c[30:0];
      f_num_q  <= e_num_q;
    end
  end

  // stage g: set up the unsigned division |num|*2^24 / D^2
  // the quotient only matters below 2^32, anything larger saturates; this also
  // covers a zero denominator
  logic [31:0] mag_c;
  div_t        div_c;

  always_comb begin
    mag_c        = f_num_q[31] ? 32'(~f_num_q + 32'sd1) : f_num_q;
    div_c.r      = {7'b0, mag_c[31:8]};
    div_c.d      = f_den2_q;
    div_c.nb     = {mag_c[7:0], 24'b0};
    div_c.q      = '0;
    div_c.neg    = f_num_q[31];
    div_c.zero   = (f_num_q == 32'sd0);
    div_c.ovf    = {7'b0, mag_c} >= {f_den2_q, 8'b0};
    div_c.on_edge = f_edge_q;
    div_c.base   = f_base_q;
  end

  div_t g_div_q;

  always_ff @(posedge clk_i) begin
    if (adv[6]) begin
      g_div_q <= div_c;
    end
  end

  // divider chain, one quotient bit per cell
  logic [NUM_DIV_CELLS:0] cv;
  logic [NUM_DIV_CELLS:0] cadv;
  div_t                   cd [NUM_DIV_CELLS+1];

  assign cv[0]              = v_q[NFRONT-1];
  assign cd[0]              = g_div_q;
  assign chain_adv          = cadv[0];
  assign cadv[NUM_DIV_CELLS] = out_adv;

  for (genvar i = 0; i < NUM_DIV_CELLS; i++) begin : g_cell
    fsfu_div_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .in_valid_i  (cv[i]),
      .in_data_i   (cd[i]),
      .in_adv_o    (cadv[i]),
      .out_valid_o (cv[i+1]),
      .out_data_o  (cd[i+1]),
      .out_adv_i   (cadv[i+1])
    );
  end

  // finish: signed, saturated force and the final difference
  div_t               fin;
  logic signed [31:0] force_c, accel_c;
  logic signed [33:0] acc_c;

  always_comb begin
    fin = cd[NUM_DIV_CELLS];
    if (fin.zero) begin
      force_c = '0;
    end else if (fin.ovf) begin
      force_c = fin.neg ? MIN32 : MAX32;
    end else if (fin.neg) begin
      force_c = (fin.q > 32'h8000_0000) ? MIN32 : 32'(~fin.q + 32'd1);
    end else begin
      force_c = fin.q[31] ? MAX32 : fin.q;
    end
    acc_c = 34'(fin.base) - 34'(force_c);
    if (fin.on_edge) begin
      accel_c = '0;
    end else if (acc_c > 34'(MAX32)) begin
      accel_c = MAX32;
    end else if (acc_c < 34'(MIN32)) begin
      accel_c = MIN32;
    end else begin
      accel_c = acc_c[31:0];
    end
  end

  // output register
  logic signed [31:0] accel_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_adv) begin
      out_valid_q <= cv[NUM_DIV_CELLS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_adv) begin
      accel_q <= accel_c;
    end
  end

  assign rsp_o.valid      = out_valid_q;
  assign rsp_o.data.accel = accel_q;
endmodule

### src/fsfu_chk.sv
// port-level checks for the stencil force block, bound to the top level
`timescale 1ns / 1ps
module fsfu_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        req_valid,
  input logic        req_ready,
  input logic        rsp_valid,
  input logic        rsp_ready,
  input logic [31:0] rsp_accel
);
  localparam int unsigned DEPTH = 40;

  logic [5:0] inflight_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inflight_q <= '0;
    end else begin
      inflight_q <= inflight_q + 6'(req_valid && req_ready) - 6'(rsp_valid && rsp_ready);
    end
  end

  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_accel))
    else $error("response dropped or changed while stalled");

  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid |-> inflight_q != 6'd0)
    else $error("response without a pending request");

  a_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    inflight_q <= 6'(DEPTH))
    else $error("more requests in flight than pipeline stages");

  a_empty_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    inflight_q == 6'd0 |-> req_ready)
    else $error("empty pipeline refuses requests");
endmodule

bind field_stencil_force_update fsfu_chk u_fsfu_chk (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .req_valid (req_i.valid),
  .req_ready (req_i.ready),
  .rsp_valid (rsp_o.valid),
  .rsp_ready (rsp_o.ready),
  .rsp_accel (rsp_o.data.accel)
);
